FILE: design/mdar_pkg.sv
package mdar_pkg;

  localparam int FUNC_W  = 2;
  localparam int DELAY_W = 10;
  localparam int CHAN_W  = 4;
  localparam int WORD_W  = 32;
  localparam int SUM_W   = DELAY_W + 1;
  localparam int STEP_W  = 4;

  localparam logic [DELAY_W-1:0] MAX_DELAY_RST = 10'd1023;

  localparam logic signed [WORD_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [WORD_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_PUSH = 2'd0,
    FUNC_PULL = 2'd1,
    FUNC_PEEK = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REDUCE,
    ST_MOD,
    ST_RD,
    ST_DONE,
    ST_PULL_RD,
    ST_PULL_EMIT
  } state_t;

endpackage

FILE: design/mdar_if.sv
interface mdar_in_if;
  import mdar_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [FUNC_W-1:0]         func;
  logic [DELAY_W-1:0]        delay_slots;
  logic signed [WORD_W-1:0]  amplitude;
  logic [CHAN_W-1:0]         channel;
  modport source (output valid, func, delay_slots, amplitude, channel, input ready);
  modport sink (input valid, func, delay_slots, amplitude, channel, output ready);
endinterface

interface mdar_out_if;
  import mdar_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [WORD_W-1:0]  slot_value;
  logic [CHAN_W-1:0]         out_channel;
  logic                      last;
  logic                      bad_delay;
  logic                      bad_channel;
  logic                      saturated;
  modport source (output valid, slot_value, out_channel, last, bad_delay, bad_channel,
                  saturated, input ready);
  modport sink (input valid, slot_value, out_channel, last, bad_delay, bad_channel,
                saturated, output ready);
endinterface

interface mdar_cfg_if;
  import mdar_pkg::*;
  logic                valid;
  logic                ready;
  logic [DELAY_W-1:0]  max_delay_slots;
  modport source (output valid, max_delay_slots, input ready);
  modport sink (input valid, max_delay_slots, output ready);
endinterface

FILE: design/mdar_ram.sv
module mdar_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [mdar_pkg::WORD_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [mdar_pkg::WORD_W-1:0] rdata
);
  import mdar_pkg::*;

  logic [WORD_W-1:0] mem_r [DEPTH];
  logic [WORD_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: design/mdar_mod.sv
module mdar_mod (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [mdar_pkg::SUM_W-1:0]   dividend,
  input  logic [mdar_pkg::SUM_W-1:0]   divisor,
  output logic                        done,
  output logic [mdar_pkg::DELAY_W-1:0] rem
);
  import mdar_pkg::*;

  logic [SUM_W-1:0]   dvd_r, dvd_nxt;
  logic [DELAY_W-1:0] rem_r, rem_nxt;
  logic [STEP_W-1:0]  cnt_r, cnt_nxt;
  logic               done_r, done_nxt;
  logic [SUM_W-1:0]   shifted;

  // restoring remainder, one dividend bit per cycle
  always_comb begin
    shifted  = {rem_r, dvd_r[SUM_W-1]};
    dvd_nxt  = dvd_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = STEP_W'(SUM_W);
    end else if (cnt_r != '0) begin
      dvd_nxt  = dvd_r << 1;
      rem_nxt  = (shifted >= divisor) ? DELAY_W'(shifted - divisor) : DELAY_W'(shifted);
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == STEP_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: design/multichannel_delay_accumulator_ring.sv
// Timing wheel of CHANNELS delayed-event accumulators in one slot memory with a single
// read port and a single write port. After reset a clearing pass writes zero to every
// one of the CHANNELS * 2**ceil(log2(SLOTS)) words (4096 by default), during which no
// transaction is taken on the input but the configuration port is open. A push or a
// peek goes through accept, memory read, and write back with result, the read being
// skipped when its channel is out of range; a push on a valid channel whose delay is
// not below the ring length also passes through the bit-serial remainder unit. A pull
// does one memory read and one clear per channel. A write of max_delay_slots in idle
// is followed by a pass through the remainder unit that brings the ring position into
// the new ring length; ring length is max_delay_slots + 1, limited to SLOTS. Results
// are held in an output register, so the next transaction is taken while the last
// result waits; a result that cannot be loaded stretches its item by the cycles it waits.
module multichannel_delay_accumulator_ring #(
  parameter int CHANNELS = 4,
  parameter int SLOTS    = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  mdar_in_if.sink    in_if,
  mdar_out_if.source out_if,
  mdar_cfg_if.sink   cfg_if
);
  import mdar_pkg::*;

  localparam int SW      = $clog2(SLOTS);
  localparam int CW      = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH   = CHANNELS * (2 ** SW);
  localparam int AW      = $clog2(DEPTH);
  localparam int LEN_CAP = (SLOTS < (2 ** DELAY_W)) ? SLOTS : (2 ** DELAY_W);
  localparam int CHL_W   = CHAN_W + 1;
  localparam logic [SUM_W-1:0] LEN_MAX  = SUM_W'(LEN_CAP);
  localparam logic [CW-1:0]    LAST_CH  = CW'(CHANNELS - 1);
  localparam logic [CHL_W-1:0] CHAN_LIM = CHL_W'(CHANNELS);
  localparam logic [AW-1:0]    CLR_LAST = AW'(DEPTH - 1);

  function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] ch,
                                               input logic [DELAY_W-1:0] pos);
    return AW'({ch, SW'(pos)});
  endfunction

  state_t state_r, state_nxt;

  logic [DELAY_W-1:0]       max_r;
  logic [DELAY_W-1:0]       cur_r;
  logic [AW-1:0]            clr_r;
  logic [FUNC_W-1:0]        func_r;
  logic [CHAN_W-1:0]        ch_r;
  logic signed [WORD_W-1:0] amp_r;
  logic                     bad_ch_r;
  logic                     bad_dly_r;
  logic [AW-1:0]            addr_r;
  logic [CW-1:0]            c_r;

  logic                     ov_r;
  logic signed [WORD_W-1:0] val_r, val_nxt;
  logic [CHAN_W-1:0]        och_r, och_nxt;
  logic                     last_r, last_nxt;
  logic                     bd_r, bd_nxt;
  logic                     bc_r, bc_nxt;
  logic                     sat_r, sat_nxt;

  logic [SUM_W-1:0]   len_full, len;
  logic [SUM_W-1:0]   sum11, cur_inc;
  logic [DELAY_W-1:0] fast_tgt, cur_adv;
  logic               need_mod, in_bad_ch, in_bad_dly;
  logic               in_ready, cfg_ready, in_acc, cfg_acc, out_free, out_load;

  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [WORD_W-1:0]  ram_wdata, ram_rdata;

  logic               mod_start, mod_done;
  logic [SUM_W-1:0]   mod_dvd;
  logic [DELAY_W-1:0] mod_rem;

  logic [WORD_W:0]          acc_sum;
  logic                     acc_sat;
  logic signed [WORD_W-1:0] acc_val;

  assign len_full = {1'b0, max_r} + SUM_W'(1);
  assign len      = (len_full > LEN_MAX) ? LEN_MAX : len_full;

  assign sum11      = {1'b0, in_if.delay_slots} + {1'b0, cur_r};
  assign fast_tgt   = (sum11 >= len) ? DELAY_W'(sum11 - len) : DELAY_W'(sum11);
  assign need_mod   = ({1'b0, in_if.delay_slots} >= len);
  assign in_bad_ch  = ({1'b0, in_if.channel} >= CHAN_LIM);
  assign in_bad_dly = (in_if.delay_slots > max_r);

  assign cur_inc = {1'b0, cur_r} + SUM_W'(1);
  assign cur_adv = (cur_inc == len) ? '0 : DELAY_W'(cur_inc);

  assign in_acc   = in_if.valid && in_ready;
  assign cfg_acc  = cfg_if.valid && cfg_ready;
  assign out_free = !ov_r || out_if.ready;

  // saturating accumulate
  assign acc_sum = {ram_rdata[WORD_W-1], ram_rdata} + {amp_r[WORD_W-1], amp_r};
  assign acc_sat = (acc_sum[WORD_W] != acc_sum[WORD_W-1]);
  assign acc_val = acc_sat ? (acc_sum[WORD_W] ? Q_MIN : Q_MAX) : acc_sum[WORD_W-1:0];

  mdar_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  mdar_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (mod_start),
    .dividend (mod_dvd),
    .divisor  (len),
    .done     (mod_done),
    .rem      (mod_rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_acc) begin
          case (in_if.func)
            FUNC_PUSH: begin
              if (in_bad_ch) begin
                state_nxt = ST_DONE;
              end else if (need_mod) begin
                state_nxt = ST_MOD;
              end else begin
                state_nxt = ST_RD;
              end
            end
            FUNC_PULL: state_nxt = ST_PULL_RD;
            FUNC_PEEK: state_nxt = in_bad_ch ? ST_DONE : ST_RD;
            default:   state_nxt = ST_IDLE;
          endcase
        end else if (cfg_acc) begin
          state_nxt = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        if (mod_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PULL_RD: state_nxt = ST_PULL_EMIT;
      ST_PULL_EMIT: begin
        if (out_free && c_r == LAST_CH) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    cfg_ready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = addr_r;
    ram_raddr = addr_r;
    ram_wdata = '0;
    mod_start = 1'b0;
    mod_dvd   = {1'b0, cur_r};
    out_load  = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        cfg_ready = 1'b1;
      end
      ST_IDLE: begin
        in_ready  = 1'b1;
        cfg_ready = !in_if.valid;
        if (in_acc && in_if.func == FUNC_PUSH && !in_bad_ch && need_mod) begin
          mod_start = 1'b1;
          mod_dvd   = sum11;
        end else if (cfg_acc) begin
          mod_start = 1'b1;
        end
      end
      ST_RD: ram_re = 1'b1;
      ST_DONE: begin
        out_load  = out_free;
        ram_we    = out_free && func_r == FUNC_PUSH && !bad_ch_r;
        ram_wdata = acc_val;
      end
      ST_PULL_RD: begin
        ram_re    = 1'b1;
        ram_raddr = slot_addr(c_r, cur_r);
      end
      ST_PULL_EMIT: begin
        out_load  = out_free;
        ram_we    = out_free;
        ram_waddr = slot_addr(c_r, cur_r);
        ram_re    = out_free && c_r != LAST_CH;
        ram_raddr = slot_addr(CW'(c_r + 1'b1), cur_r);
      end
      ST_REDUCE, ST_MOD: begin
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (state_r == ST_PULL_EMIT) begin
      val_nxt  = ram_rdata;
      och_nxt  = CHAN_W'(c_r);
      last_nxt = (c_r == LAST_CH);
      bd_nxt   = 1'b0;
      bc_nxt   = 1'b0;
      sat_nxt  = 1'b0;
    end else begin
      val_nxt  = (func_r == FUNC_PEEK && !bad_ch_r) ? ram_rdata : '0;
      och_nxt  = ch_r;
      last_nxt = 1'b1;
      bd_nxt   = bad_dly_r;
      bc_nxt   = bad_ch_r;
      sat_nxt  = func_r == FUNC_PUSH && !bad_ch_r && acc_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      max_r   <= MAX_DELAY_RST;
      cur_r   <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_acc) begin
        max_r <= cfg_if.max_delay_slots;
      end
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_REDUCE && mod_done) begin
        cur_r <= mod_rem;
      end else if (state_r == ST_PULL_EMIT && out_free && c_r == LAST_CH) begin
        cur_r <= cur_adv;
      end
      if (out_load) begin
        ov_r <= 1'b1;
      end else if (out_if.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r    <= in_if.func;
      ch_r      <= in_if.channel;
      amp_r     <= in_if.amplitude;
      bad_ch_r  <= in_bad_ch;
      bad_dly_r <= (in_if.func == FUNC_PUSH) && in_bad_dly;
      addr_r    <= (in_if.func == FUNC_PUSH) ? slot_addr(in_if.channel[CW-1:0], fast_tgt)
                                             : slot_addr(in_if.channel[CW-1:0], cur_r);
      c_r       <= '0;
    end else begin
      if (state_r == ST_MOD && mod_done) begin
        addr_r <= slot_addr(ch_r[CW-1:0], mod_rem);
      end
      if (state_r == ST_PULL_EMIT && out_free && c_r != LAST_CH) begin
        c_r <= CW'(c_r + 1'b1);
      end
    end
    if (out_load) begin
      val_r  <= val_nxt;
      och_r  <= och_nxt;
      last_r <= last_nxt;
      bd_r   <= bd_nxt;
      bc_r   <= bc_nxt;
      sat_r  <= sat_nxt;
    end
  end

  assign in_if.ready        = in_ready;
  assign cfg_if.ready       = cfg_ready;
  assign out_if.valid       = ov_r;
  assign out_if.slot_value  = val_r;
  assign out_if.out_channel = och_r;
  assign out_if.last        = last_r;
  assign out_if.bad_delay   = bd_r;
  assign out_if.bad_channel = bc_r;
  assign out_if.saturated   = sat_r;

`ifndef NO_ASSERTIONS
  // ring position stays inside the ring whenever a transaction can be taken
  a_pos_in_ring: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> {1'b0, cur_r} < len)
    else $error("ring position outside ring length");

  // a pull never reads the word it is clearing
  a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we && ram_re |-> ram_waddr != ram_raddr)
    else $error("slot read and write on the same word");

  // final pull result returns the block to idle
  a_pull_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_load && state_r == ST_PULL_EMIT && c_r == LAST_CH |=> state_r == ST_IDLE)
    else $error("pull did not finish after last channel");
`endif

endmodule

FILE: test/tb.sv
module tb;
  import mdar_pkg::*;

  localparam int CHANNELS = 4;
  localparam int SLOTS = 1024;
  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;
  localparam int SETTLE_CYCLES = 24;
  localparam int STALL_LIMIT = 20000;
  localparam int PHASE_ITEMS = 36;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [DELAY_W-1:0] delay_slots;
    logic [WORD_W-1:0] amplitude;
    logic [CHAN_W-1:0] channel;
  } item_t;

  typedef struct packed {
    logic [WORD_W-1:0] slot_value;
    logic [CHAN_W-1:0] out_channel;
    logic last;
    logic bad_delay;
    logic bad_channel;
    logic saturated;
  } result_t;

  typedef enum logic [0:0] {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t kind;
    item_t item;
    logic [DELAY_W-1:0] limit;
    logic fixed;
    result_t res;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;

  mdar_in_if in_ch();
  mdar_out_if out_ch();
  mdar_cfg_if cfg_ch();

  multichannel_delay_accumulator_ring #(
    .CHANNELS(CHANNELS),
    .SLOTS(SLOTS)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_if(in_ch),
    .out_if(out_ch),
    .cfg_if(cfg_ch)
  );

  always #2 clk = ~clk;

  // wheel predictor state
  logic [WORD_W-1:0] wheel_mem [0:CHANNELS*SLOTS-1];
  int cur_pos;
  logic [DELAY_W-1:0] limit_q;
  result_t slot_expect [$];

  int error_count = 0;
  int burst_left = 0;
  int n_push = 0, n_pull = 0, n_peek = 0, n_nop = 0, n_cfg = 0;
  int n_sat = 0, n_bad_delay = 0, n_bad_chan = 0, n_checked = 0;
  int quiet_cycles = 0;

  row_t dir_rows [$];

  function automatic row_t op_row(logic [FUNC_W-1:0] f, logic [DELAY_W-1:0] d,
                                  logic [WORD_W-1:0] a, logic [CHAN_W-1:0] ch);
    row_t r;
    r = '0;
    r.kind = ROW_ITEM;
    r.item.func = f;
    r.item.delay_slots = d;
    r.item.amplitude = a;
    r.item.channel = ch;
    return r;
  endfunction

  function automatic row_t chk_row(logic [FUNC_W-1:0] f, logic [DELAY_W-1:0] d,
                                   logic [WORD_W-1:0] a, logic [CHAN_W-1:0] ch,
                                   logic [WORD_W-1:0] v, logic bd, logic bc, logic sat);
    row_t r;
    r = op_row(f, d, a, ch);
    r.fixed = 1'b1;
    r.res.slot_value = v;
    r.res.out_channel = ch;
    r.res.last = 1'b1;
    r.res.bad_delay = bd;
    r.res.bad_channel = bc;
    r.res.saturated = sat;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [DELAY_W-1:0] v);
    row_t r;
    r = '0;
    r.kind = ROW_CFG;
    r.limit = v;
    return r;
  endfunction

  task automatic add_row(input row_t r);
    dir_rows.insert(dir_rows.size(), r);
  endtask

  task automatic queue_result(input result_t r);
    slot_expect.insert(slot_expect.size(), r);
  endtask

  // advance the wheel by one transaction and queue what it yields
  task automatic wheel_step(input item_t it, input logic fixed, input result_t fixed_res);
    int len;
    int pos;
    int tgt;
    logic signed [WORD_W-1:0] old_v;
    logic signed [WORD_W:0] sum;
    result_t r;
    len = int'(limit_q) + 1;
    if (len > SLOTS) len = SLOTS;
    pos = cur_pos % len;
    r = '0;
    case (it.func)
      FUNC_PUSH: begin
        n_push++;
        r.out_channel = it.channel;
        r.last = 1'b1;
        r.bad_delay = it.delay_slots > limit_q;
        r.bad_channel = it.channel >= CHANNELS;
        if (!r.bad_channel) begin
          tgt = int'(it.channel) * SLOTS + (int'(it.delay_slots) + pos) % len;
          old_v = wheel_mem[tgt];
          sum = old_v + $signed(it.amplitude);
          if (sum > Q_MAX) begin
            sum = Q_MAX;
            r.saturated = 1'b1;
          end else if (sum < Q_MIN) begin
            sum = Q_MIN;
            r.saturated = 1'b1;
          end
          wheel_mem[tgt] = sum[WORD_W-1:0];
        end
        if (r.saturated) n_sat++;
        if (r.bad_delay) n_bad_delay++;
        if (r.bad_channel) n_bad_chan++;
        queue_result(fixed ? fixed_res : r);
      end
      FUNC_PULL: begin
        n_pull++;
        for (int c = 0; c < CHANNELS; c++) begin
          r.slot_value = wheel_mem[c*SLOTS + pos];
          r.out_channel = CHAN_W'(c);
          r.last = (c == CHANNELS - 1);
          queue_result(r);
          wheel_mem[c*SLOTS + pos] = '0;
        end
        cur_pos = (pos + 1) % len;
      end
      FUNC_PEEK: begin
        n_peek++;
        r.out_channel = it.channel;
        r.last = 1'b1;
        r.bad_channel = it.channel >= CHANNELS;
        if (!r.bad_channel) r.slot_value = wheel_mem[int'(it.channel)*SLOTS + pos];
        if (r.bad_channel) n_bad_chan++;
        queue_result(fixed ? fixed_res : r);
      end
      default: n_nop++;
    endcase
  endtask

  task automatic idle(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 10);
      if (gap > 0) idle(gap);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
    burst_left--;
  endtask

  task automatic send_item(input item_t it, input logic fixed, input result_t fixed_res);
    in_ch.valid <= 1'b1;
    in_ch.func <= it.func;
    in_ch.delay_slots <= it.delay_slots;
    in_ch.amplitude <= it.amplitude;
    in_ch.channel <= it.channel;
    do @(posedge clk); while (!in_ch.ready);
    wheel_step(it, fixed, fixed_res);
  endtask

  // hold the input until every result is back and the block has gone quiet
  task automatic settle();
    in_ch.valid <= 1'b0;
    while (slot_expect.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_limit(input logic [DELAY_W-1:0] v);
    settle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.max_delay_slots <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    limit_q = v;
    n_cfg++;
  endtask

  function automatic item_t rand_item();
    item_t it;
    int sel;
    int pick;
    sel = $urandom_range(0, 99);
    if (sel < 45) it.func = FUNC_PUSH;
    else if (sel < 70) it.func = FUNC_PULL;
    else if (sel < 93) it.func = FUNC_PEEK;
    else it.func = FUNC_NOP;
    if ($urandom_range(0, 9) == 0) it.channel = CHAN_W'($urandom_range(CHANNELS, 15));
    else it.channel = CHAN_W'($urandom_range(0, CHANNELS - 1));
    pick = $urandom_range(0, 19);
    if (pick < 15) it.delay_slots = DELAY_W'($urandom_range(0, int'(limit_q)));
    else if (pick < 18) it.delay_slots = DELAY_W'($urandom);
    else it.delay_slots = limit_q + 1'b1;
    pick = $urandom_range(0, 9);
    if (pick < 4) begin
      it.amplitude = WORD_W'($urandom_range(0, 32'h0004_0000));
      if ($urandom_range(0, 1)) it.amplitude = -it.amplitude;
    end else if (pick < 7) begin
      it.amplitude = $urandom;
    end else if ($urandom_range(0, 1)) begin
      it.amplitude = Q_MAX - WORD_W'($urandom_range(0, 255));
    end else begin
      it.amplitude = Q_MIN + WORD_W'($urandom_range(0, 255));
    end
    return it;
  endfunction

  task automatic check_result(input result_t exp_r);
    if (out_ch.slot_value !== exp_r.slot_value) begin
      $error("slot_value: expected %0d, got %0d", $signed(exp_r.slot_value),
             out_ch.slot_value);
      error_count++;
    end
    if (out_ch.out_channel !== exp_r.out_channel) begin
      $error("out_channel: expected %0d, got %0d", exp_r.out_channel, out_ch.out_channel);
      error_count++;
    end
    if (out_ch.last !== exp_r.last) begin
      $error("last: expected %0d, got %0d", exp_r.last, out_ch.last);
      error_count++;
    end
    if (out_ch.bad_delay !== exp_r.bad_delay) begin
      $error("bad_delay: expected %0d, got %0d", exp_r.bad_delay, out_ch.bad_delay);
      error_count++;
    end
    if (out_ch.bad_channel !== exp_r.bad_channel) begin
      $error("bad_channel: expected %0d, got %0d", exp_r.bad_channel, out_ch.bad_channel);
      error_count++;
    end
    if (out_ch.saturated !== exp_r.saturated) begin
      $error("saturated: expected %0d, got %0d", exp_r.saturated, out_ch.saturated);
      error_count++;
    end
  endtask

  // result receiver with its own stall pattern
  initial begin
    logic [15:0] stall_pat;
    int mode;
    int cnt;
    stall_pat = 16'b1011_0111_0010_1101;
    mode = 0;
    cnt = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (cnt == 0) begin
        mode = $urandom_range(0, 2);
        cnt = $urandom_range(16, 96);
      end
      cnt--;
      stall_pat = {stall_pat[14:0], stall_pat[15]};
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= stall_pat[0];
        default: out_ch.ready <= $urandom_range(0, 1);
      endcase
    end
  end

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      n_checked++;
      if (slot_expect.size() == 0) begin
        $error("unexpected result: channel %0d value %0d", out_ch.out_channel,
               out_ch.slot_value);
        error_count++;
      end else begin
        check_result(slot_expect.pop_front());
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb: stalled, %0d results still awaited", slot_expect.size());
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    logic [DELAY_W-1:0] phase_lim [7];
    result_t none;
    none = '0;
    phase_lim = '{10'd1023, 10'd15, 10'd0, 10'd1, 10'd0, 10'd1023, 10'd7};
    phase_lim[4] = DELAY_W'($urandom_range(2, 1022));
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.func = FUNC_PUSH;
    in_ch.delay_slots = '0;
    in_ch.amplitude = '0;
    in_ch.channel = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.max_delay_slots = '0;
    for (int i = 0; i < CHANNELS*SLOTS; i++) wheel_mem[i] = '0;
    cur_pos = 0;
    limit_q = MAX_DELAY_RST;

    add_row(chk_row(FUNC_PEEK, 0, 0, 0, 0, 0, 0, 0));
    add_row(op_row(FUNC_PULL, 0, 0, 0));
    add_row(chk_row(FUNC_PUSH, 0, 32'h7fff_ffff, 0, 0, 0, 0, 0));
    add_row(chk_row(FUNC_PUSH, 0, 32'h0000_0001, 0, 0, 0, 0, 1));
    add_row(chk_row(FUNC_PEEK, 0, 0, 0, 32'h7fff_ffff, 0, 0, 0));
    add_row(chk_row(FUNC_PUSH, 0, 32'h8000_0000, 1, 0, 0, 0, 0));
    add_row(chk_row(FUNC_PUSH, 0, 32'h8000_0000, 1, 0, 0, 0, 1));
    add_row(chk_row(FUNC_PEEK, 0, 0, 1, 32'h8000_0000, 0, 0, 0));
    add_row(chk_row(FUNC_PUSH, 10'd1023, 32'h0000_0005, 15, 0, 0, 1, 0));
    add_row(chk_row(FUNC_PEEK, 0, 0, 4, 0, 0, 1, 0));
    add_row(op_row(FUNC_NOP, 10'h3ff, 32'hffff_ffff, 15));
    add_row(op_row(FUNC_PULL, 0, 0, 0));
    add_row(chk_row(FUNC_PUSH, 10'd1023, 32'hffff_ffff, 3, 0, 0, 0, 0));
    add_row(op_row(FUNC_PUSH, 1, 32'h1234_5678, 2));
    add_row(op_row(FUNC_PULL, 0, 0, 0));
    add_row(op_row(FUNC_PULL, 0, 0, 0));
    add_row(cfg_row(10'd0));
    add_row(chk_row(FUNC_PUSH, 5, 32'h0000_0003, 0, 0, 1, 0, 0));
    add_row(chk_row(FUNC_PUSH, 10'd1023, 32'h0000_0003, 15, 0, 1, 1, 0));
    add_row(op_row(FUNC_PEEK, 0, 0, 0));
    add_row(op_row(FUNC_PULL, 0, 0, 0));
    add_row(cfg_row(10'd3));
    add_row(chk_row(FUNC_PUSH, 4, 32'h0000_0007, 1, 0, 1, 0, 0));
    add_row(op_row(FUNC_PUSH, 3, 32'hffff_fff9, 1));
    add_row(op_row(FUNC_PULL, 0, 0, 0));
    add_row(op_row(FUNC_PULL, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        write_limit(dir_rows[i].limit);
      end else begin
        pace();
        send_item(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].res);
      end
    end

    foreach (phase_lim[p]) begin
      write_limit(phase_lim[p]);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (k == PHASE_ITEMS / 2 && p == 2) settle();
        pace();
        send_item(rand_item(), 1'b0, none);
      end
    end

    settle();
    $display("tb: %0d push, %0d pull, %0d peek, %0d no-op transactions, %0d results checked",
             n_push, n_pull, n_peek, n_nop, n_checked);
    $display("tb: %0d limit writes, %0d saturations, %0d long delays, %0d bad channels",
             n_cfg, n_sat, n_bad_delay, n_bad_chan);
    if (error_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule
